@@ src/cpu8_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cpu8_pkg;

  localparam int RegCount = 16;
  localparam int RegIdxW  = 4;

  // group 8 sub-opcodes
  localparam logic [3:0] OP_MOV  = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_AND  = 4'h2;
  localparam logic [3:0] OP_OR   = 4'h3;
  localparam logic [3:0] OP_XOR  = 4'h4;
  localparam logic [3:0] OP_CMPC = 4'h5;
  localparam logic [3:0] OP_ADDC = 4'h6;
  localparam logic [3:0] OP_CMP  = 4'h7;
  localparam logic [3:0] OP_SUB  = 4'h8;
  localparam logic [3:0] OP_SUBC = 4'h9;
  localparam logic [3:0] OP_SLL  = 4'ha;
  localparam logic [3:0] OP_SLLC = 4'hb;
  localparam logic [3:0] OP_SRL  = 4'hc;
  localparam logic [3:0] OP_SRLC = 4'hd;
  localparam logic [3:0] OP_SRA  = 4'he;
  localparam logic [3:0] OP_MISC = 4'hf;

  localparam logic [15:0] PcMask     = 16'hfffe;
  localparam logic [15:0] ExtMask    = 16'hf11f;
  localparam logic [15:0] ExtCode    = 16'h810f;
  localparam logic [15:0] AdjMask    = 16'hf0ff;
  localparam logic [15:0] DaaCode    = 16'h801f;
  localparam logic [15:0] DasCode    = 16'h803f;
  localparam logic [15:0] NegCode    = 16'h805f;
  localparam logic [7:0]  AdjLo      = 8'h06;
  localparam logic [7:0]  AdjHi      = 8'h60;
  localparam logic [7:0]  DasLimit   = 8'h99;
  localparam logic [3:0]  NibbleMax  = 4'h9;

  typedef struct packed {
    logic c;
    logic z;
    logic s;
    logic v;
    logic h;
  } flags_t;

  typedef struct packed {
    logic                status;
    logic [15:0]         next_pc;
    logic                reg_write;
    logic [RegIdxW-1:0]  reg_index;
    logic [7:0]          reg_value;
    flags_t              flags;
  } result_t;

  // control from sequencer to shifter
  typedef struct packed {
    logic       load;
    logic       step;
    logic [2:0] mode;   // 0 sll,1 sllc,2 srl,3 srlc,4 sra
  } shift_ctl_t;

  localparam logic [2:0] SH_SLL  = 3'd0;
  localparam logic [2:0] SH_SLLC = 3'd1;
  localparam logic [2:0] SH_SRL  = 3'd2;
  localparam logic [2:0] SH_SRLC = 3'd3;
  localparam logic [2:0] SH_SRA  = 3'd4;

endpackage
`default_nettype wire

@@ src/cpu8_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface cpu8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_word;
  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface cpu8_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] next_pc;
  logic        reg_write;
  logic [3:0]  reg_index;
  logic [7:0]  reg_value;
  logic        flag_carry;
  logic        flag_zero;
  logic        flag_sign;
  logic        flag_overflow;
  logic        flag_half_carry;
  modport source (output valid, status, next_pc, reg_write, reg_index, reg_value,
                  flag_carry, flag_zero, flag_sign, flag_overflow, flag_half_carry,
                  input ready);
  modport sink (input valid, status, next_pc, reg_write, reg_index, reg_value,
                flag_carry, flag_zero, flag_sign, flag_overflow, flag_half_carry,
                output ready);
endinterface
`default_nettype wire

@@ src/cpu8_shifter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One bit per step over a 16-bit window; carry holds the last bit out.
module cpu8_shifter (
  input  wire logic                clk,
  input  wire cpu8_pkg::shift_ctl_t ctl,
  input  wire logic [7:0]          rn,
  input  wire logic [7:0]          nb,
  output logic [7:0]               value,
  output logic                     carry
);
  import cpu8_pkg::*;

  logic [15:0] win_r, win_nxt;
  logic        c_r, c_nxt;
  logic [2:0]  mode_r;

  always_comb begin
    win_nxt = win_r;
    c_nxt   = c_r;
    if (ctl.load) begin
      if (ctl.mode == SH_SLL || ctl.mode == SH_SLLC) win_nxt = {rn, nb};
      else                                            win_nxt = {nb, rn};
    end else if (ctl.step) begin
      unique case (mode_r)
        SH_SLL, SH_SLLC: begin
          c_nxt   = win_r[15];
          win_nxt = {win_r[14:0], 1'b0};
        end
        SH_SRA: begin
          c_nxt   = win_r[0];
          win_nxt = {8'h00, win_r[7], win_r[7:1]};
        end
        default: begin
          c_nxt   = win_r[0];
          win_nxt = {1'b0, win_r[15:1]};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    c_r   <= c_nxt;
    if (ctl.load) mode_r <= ctl.mode;
  end

  assign value = (mode_r == SH_SLL || mode_r == SH_SLLC) ? win_r[15:8] : win_r[7:0];
  assign carry = c_r;
endmodule
`default_nettype wire

@@ src/cpu8_alu_execute_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ALU, compare and adjust forms go from the accepted transaction through the EXEC
// and OUT states to the result; shifts first pass through SHIFT, one bit per cycle
// in the shifter for Rm & 7 bits. One instruction in flight; in_ready is low until
// the result is taken, so no new transaction is accepted before the result leaves.
// Reset (synchronous, rst_n low) clears registers, flags and program counter.
module cpu8_alu_execute_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cpu8_in_if.sink     in_ch,
  cpu8_out_if.source  out_ch
);
  import cpu8_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  rf_r [RegCount];
  flags_t      fl_r, fl_nxt;
  logic [15:0] pc_r;
  logic [15:0] w_r;
  logic [7:0]  rn_r, src_r;
  logic [2:0]  cnt_r, cnt_nxt;
  result_t     res_r, res_nxt;
  logic        wr_en;
  shift_ctl_t  sctl;
  logic [7:0]  sh_val;
  logic        sh_c;

  logic [3:0] grp, n_f, m_f, sub, op;
  assign grp = in_ch.instr_word[15:12];
  assign n_f = in_ch.instr_word[11:8];
  assign m_f = in_ch.instr_word[7:4];
  assign sub = in_ch.instr_word[3:0];

  logic [3:0] w_grp, w_n;
  assign w_grp = w_r[15:12];
  assign w_n   = w_r[11:8];
  assign op    = (w_grp < 4'd8) ? w_grp : w_r[3:0];

  logic accept;
  assign accept = in_ch.valid && (state_r == ST_IDLE);
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    sctl.load = accept && grp == 4'd8 && sub >= OP_SLL && sub <= OP_SRA;
    sctl.step = (state_r == ST_SHIFT) && cnt_r != 3'd0;
    unique case (sub)
      OP_SLL:  sctl.mode = SH_SLL;
      OP_SLLC: sctl.mode = SH_SLLC;
      OP_SRL:  sctl.mode = SH_SRL;
      OP_SRLC: sctl.mode = SH_SRLC;
      default: sctl.mode = SH_SRA;
    endcase
  end

  logic [7:0] nb_sel;
  assign nb_sel = (sub == OP_SLLC) ? rf_r[n_f - 4'd1] :
                  (sub == OP_SRLC) ? rf_r[n_f + 4'd1] : 8'h00;

  cpu8_shifter u_shift (
    .clk(clk), .ctl(sctl), .rn(rf_r[n_f]), .nb(nb_sel), .value(sh_val), .carry(sh_c)
  );

  // shared add/sub datapath
  logic       is_sub, use_c;
  logic [8:0] t9;
  logic [4:0] h5;
  logic [7:0] l8;
  logic       cin;
  always_comb begin
    is_sub = (op == OP_CMPC || op == OP_CMP || op == OP_SUB || op == OP_SUBC);
    use_c  = (op == OP_CMPC || op == OP_ADDC || op == OP_SUBC);
    cin    = use_c & fl_r.c;
    if (is_sub) begin
      t9 = {1'b0, rn_r} - {1'b0, src_r} - {8'h00, cin};
      h5 = {1'b0, rn_r[3:0]} - {1'b0, src_r[3:0]} - {4'h0, cin};
      l8 = {1'b0, rn_r[6:0]} - {1'b0, src_r[6:0]} - {7'h00, cin};
    end else begin
      t9 = {1'b0, rn_r} + {1'b0, src_r} + {8'h00, cin};
      h5 = {1'b0, rn_r[3:0]} + {1'b0, src_r[3:0]} + {4'h0, cin};
      l8 = {1'b0, rn_r[6:0]} + {1'b0, src_r[6:0]} + {7'h00, cin};
    end
  end

  logic       lo_adj, hi_adj;
  logic [8:0] daa_t;
  logic [7:0] das_t;
  always_comb begin
    lo_adj = fl_r.h || (rn_r[3:0] > NibbleMax);
    daa_t  = {1'b0, rn_r} + (lo_adj ? {1'b0, AdjLo} : 9'h000);
    das_t  = rn_r - (lo_adj ? AdjLo : 8'h00);
  end

  always_comb begin
    logic [7:0] v;
    logic       wr, ok;
    state_nxt = state_r;
    fl_nxt    = fl_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    hi_adj    = 1'b0;
    v  = 8'h00;
    wr = 1'b1;
    ok = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = rf_r[m_f][2:0];
          state_nxt = (sctl.load) ? ST_SHIFT : ST_EXEC;
        end
      end
      ST_SHIFT: begin
        if (cnt_r != 3'd0) cnt_nxt = cnt_r - 3'd1;
        else state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (w_grp > 4'd8) begin
          ok = 1'b0;
        end else if (w_grp == 4'd8 && op >= OP_SUB) begin
          priority case (1'b1)
            op == OP_SUB || op == OP_SUBC: begin
              v = t9[7:0];
              fl_nxt.h = h5[4]; fl_nxt.v = l8[7] ^ t9[8]; fl_nxt.c = t9[8];
              fl_nxt.z = (v == 8'h00); fl_nxt.s = v[7];
            end
            op != OP_MISC: begin
              v = sh_val;
              if (src_r[2:0] != 3'd0) fl_nxt.c = sh_c;
            end
            (w_r & ExtMask) == ExtCode: begin
              v = src_r[7] ? 8'hff : 8'h00;
              fl_nxt.z = (src_r == 8'h00); fl_nxt.s = src_r[7];
            end
            (w_r & AdjMask) == DaaCode: begin
              hi_adj = fl_r.c || daa_t >= 9'h0a0;
              v = daa_t[7:0] + (hi_adj ? AdjHi : 8'h00);
              fl_nxt.h = lo_adj; fl_nxt.c = hi_adj;
              fl_nxt.z = (v == 8'h00); fl_nxt.s = v[7];
            end
            (w_r & AdjMask) == DasCode: begin
              hi_adj = fl_r.c || rn_r > DasLimit;
              v = das_t - (hi_adj ? AdjHi : 8'h00);
              fl_nxt.h = lo_adj; fl_nxt.c = hi_adj;
              fl_nxt.z = (v == 8'h00); fl_nxt.s = v[7];
            end
            (w_r & AdjMask) == NegCode: begin
              v = 8'h00 - rn_r;
              fl_nxt.h = (rn_r[3:0] == 4'h0); fl_nxt.c = (rn_r == 8'h00);
              fl_nxt.v = (rn_r[6:0] == 7'h00) ^ (rn_r == 8'h00);
              fl_nxt.z = (v == 8'h00); fl_nxt.s = v[7];
            end
            default: ok = 1'b0;
          endcase
        end else begin
          unique case (op)
            OP_MOV: v = src_r;
            OP_AND: v = rn_r & src_r;
            OP_OR:  v = rn_r | src_r;
            OP_XOR: v = rn_r ^ src_r;
            default: begin
              v = t9[7:0];
              fl_nxt.h = h5[4]; fl_nxt.v = l8[7] ^ t9[8]; fl_nxt.c = t9[8];
              if (op == OP_CMP || op == OP_CMPC) wr = 1'b0;
            end
          endcase
          fl_nxt.z = (v == 8'h00); fl_nxt.s = v[7];
        end
        if (!ok) wr = 1'b0;
        wr_en = wr;
        res_nxt.status    = !ok;
        res_nxt.next_pc   = pc_r;
        res_nxt.reg_write = wr;
        res_nxt.reg_index = wr ? w_n : 4'h0;
        res_nxt.reg_value = wr ? v : 8'h00;
        res_nxt.flags     = fl_nxt;
        state_nxt = ST_OUT;
      end
      default: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fl_r    <= '0;
      pc_r    <= 16'h0000;
      for (int i = 0; i < RegCount; i++) rf_r[i] <= 8'h00;
    end else begin
      state_r <= state_nxt;
      fl_r    <= fl_nxt;
      if (accept) pc_r <= (pc_r & PcMask) + 16'd2;
      if (wr_en) rf_r[w_n] <= res_nxt.reg_value;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    if (accept) begin
      w_r   <= in_ch.instr_word;
      rn_r  <= rf_r[n_f];
      src_r <= (grp < 4'd8) ? in_ch.instr_word[7:0] : rf_r[m_f];
    end
  end

  assign out_ch.valid           = (state_r == ST_OUT);
  assign out_ch.status          = res_r.status;
  assign out_ch.next_pc         = res_r.next_pc;
  assign out_ch.reg_write       = res_r.reg_write;
  assign out_ch.reg_index       = res_r.reg_index;
  assign out_ch.reg_value       = res_r.reg_value;
  assign out_ch.flag_carry      = res_r.flags.c;
  assign out_ch.flag_zero       = res_r.flags.z;
  assign out_ch.flag_sign       = res_r.flags.s;
  assign out_ch.flag_overflow   = res_r.flags.v;
  assign out_ch.flag_half_carry = res_r.flags.h;
endmodule
`default_nettype wire
